>>> sv/afw_pkg.sv
// ----------------------------------------------------------------------------
// afw_pkg
// shared types and constants of the ipv4 acl forward filter
// ----------------------------------------------------------------------------
package afw_pkg;

  localparam logic [15:0] MIN_FRAME_BYTES = 16'd34;
  localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;

  // checksum accumulator: nine 16-bit words
  localparam int unsigned SUM_W = 20;

  // configuration register indexes
  localparam logic [2:0] CFG_SRC_ADDR       = 3'd0;
  localparam logic [2:0] CFG_SRC_MASK       = 3'd1;
  localparam logic [2:0] CFG_DST_ADDR       = 3'd2;
  localparam logic [2:0] CFG_DST_MASK       = 3'd3;
  localparam logic [2:0] CFG_RULE_PERMIT    = 3'd4;
  localparam logic [2:0] CFG_DEFAULT_PERMIT = 3'd5;
  localparam logic [2:0] CFG_ACTIVE_PORTS   = 3'd6;

  typedef enum logic [2:0] {
    R_NONE        = 3'd0,
    R_NO_PARTNER  = 3'd1,
    R_TOO_SHORT   = 3'd2,
    R_NOT_IPV4    = 3'd3,
    R_TTL_EXPIRED = 3'd4,
    R_ACL_DENY    = 3'd5
  } reason_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] src_ip_mask;
    logic [31:0] dst_ip;
    logic [31:0] dst_ip_mask;
    logic        rule_permit;
    logic        default_permit;
    logic [3:0]  active_ports;
  } cfg_t;

  // classified frame waiting for the back end
  typedef struct packed {
    logic             fwd;
    reason_t          reason;
    logic [2:0]       partner;
    logic [2:0]       port;
    logic             port_ok;
    logic [7:0]       ttl_out;
    logic [SUM_W-1:0] csum_sum;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

>>> sv/afw_front.sv
// ----------------------------------------------------------------------------
// afw_front
// classifies one frame summary and sums its header words
// ----------------------------------------------------------------------------
module afw_front import afw_pkg::*; #(
  parameter int NUM_PORTS = 8
) (
  input  cfg_t        cfg,
  input  logic [2:0]  in_port,
  input  logic [15:0] in_frame_length,
  input  logic [15:0] in_eth_type,
  input  logic [15:0] in_ver_ihl_tos,
  input  logic [15:0] in_total_length,
  input  logic [15:0] in_ident,
  input  logic [15:0] in_flags_fragment,
  input  logic [7:0]  in_ttl_in,
  input  logic [7:0]  in_protocol,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  output entry_t      entry
);

  logic [2:0]  partner;
  logic [31:0] active_eff;
  logic        port_ok;
  logic        src_hit;
  logic        dst_hit;
  logic        allow;
  logic [7:0]  ttl_m1;
  reason_t     reason;

  assign partner    = in_port ^ 3'd1;
  assign port_ok    = 32'(in_port) < NUM_PORTS;
  assign active_eff = (32'(cfg.active_ports) > NUM_PORTS) ? NUM_PORTS
                                                          : 32'(cfg.active_ports);

  // masked single-rule match, a zero mask matches anything
  assign src_hit = (cfg.src_ip_mask == '0) ||
                   ((in_src_ip & cfg.src_ip_mask) == (cfg.src_ip & cfg.src_ip_mask));
  assign dst_hit = (cfg.dst_ip_mask == '0) ||
                   ((in_dst_ip & cfg.dst_ip_mask) == (cfg.dst_ip & cfg.dst_ip_mask));
  assign allow   = (src_hit && dst_hit) ? cfg.rule_permit : cfg.default_permit;

  assign ttl_m1 = in_ttl_in - 8'd1;

  always_comb begin
    if (!port_ok || (32'(partner) >= active_eff)) begin
      reason = R_NO_PARTNER;
    end else if (in_frame_length < MIN_FRAME_BYTES) begin
      reason = R_TOO_SHORT;
    end else if (in_eth_type != ETHERTYPE_IPV4) begin
      reason = R_NOT_IPV4;
    end else if (in_ttl_in <= 8'd1) begin
      reason = R_TTL_EXPIRED;
    end else if (!allow) begin
      reason = R_ACL_DENY;
    end else begin
      reason = R_NONE;
    end
  end

  always_comb begin
    entry.fwd      = (reason == R_NONE);
    entry.reason   = reason;
    entry.partner  = partner;
    entry.port     = in_port;
    entry.port_ok  = port_ok;
    entry.ttl_out  = (reason == R_NONE) ? ttl_m1 : 8'd0;
    // checksum word taken as zero, ttl already decremented
    entry.csum_sum = SUM_W'(in_ver_ihl_tos) + SUM_W'(in_total_length)
                   + SUM_W'(in_ident) + SUM_W'(in_flags_fragment)
                   + SUM_W'({ttl_m1, in_protocol})
                   + SUM_W'(in_src_ip[31:16]) + SUM_W'(in_src_ip[15:0])
                   + SUM_W'(in_dst_ip[31:16]) + SUM_W'(in_dst_ip[15:0]);
  end

endmodule

>>> sv/afw_queue.sv
// ----------------------------------------------------------------------------
// afw_queue
// two-entry queue between classification and counting
// ----------------------------------------------------------------------------
module afw_queue import afw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  entry_t    push_entry,
  input  logic      pop,
  output entry_t    head,
  output q_status_t status
);

  entry_t     slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign status.empty = (count_r == 2'd0);
  assign status.full  = (count_r == 2'd2);

endmodule

>>> sv/afw_back.sv
// ----------------------------------------------------------------------------
// afw_back
// per-port counters, checksum fold and the result register
// ----------------------------------------------------------------------------
module afw_back import afw_pkg::*; #(
  parameter int NUM_PORTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  entry_t      head,
  input  q_status_t   q_status,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_forward,
  output logic [2:0]  out_drop_reason,
  output logic [2:0]  out_port,
  output logic [7:0]  out_ttl_out,
  output logic [15:0] out_header_checksum,
  output logic [63:0] out_rx_total,
  output logic [63:0] out_tx_total,
  output logic [63:0] out_drop_total
);

  // only ports reachable through a 3-bit ingress field need counters
  localparam int CNT_DEPTH = (NUM_PORTS < 8) ? NUM_PORTS : 8;

  logic [63:0] rx_r   [CNT_DEPTH];
  logic [63:0] tx_r   [CNT_DEPTH];
  logic [63:0] drop_r [CNT_DEPTH];

  logic        out_valid_r;
  logic        load;
  logic [63:0] rx_sel, tx_sel, drop_sel;
  logic [63:0] rx_inc, tx_inc, drop_inc;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] csum;

  logic        fwd_r;
  logic [2:0]  reason_r;
  logic [2:0]  port_r;
  logic [7:0]  ttl_r;
  logic [15:0] csum_r;
  logic [63:0] rx_out_r, tx_out_r, drop_out_r;

  assign load = !q_status.empty && (!out_valid_r || !out_stall);
  assign pop  = load;

  always_comb begin
    rx_sel   = '0;
    tx_sel   = '0;
    drop_sel = '0;
    for (int i = 0; i < CNT_DEPTH; i++) begin
      if (head.port_ok && (head.port == 3'(i))) begin
        rx_sel   = rx_r[i];
        tx_sel   = tx_r[i];
        drop_sel = drop_r[i];
      end
    end
  end

  assign rx_inc   = rx_sel + 64'd1;
  assign tx_inc   = tx_sel + 64'd1;
  assign drop_inc = drop_sel + 64'd1;

  // end-around carry fold, twice
  assign fold1 = {1'b0, head.csum_sum[15:0]} + 17'(head.csum_sum[SUM_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign csum  = (fold2 == 16'hFFFF) ? 16'hFFFF : ~fold2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < CNT_DEPTH; i++) begin
        rx_r[i]   <= '0;
        tx_r[i]   <= '0;
        drop_r[i] <= '0;
      end
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        for (int i = 0; i < CNT_DEPTH; i++) begin
          if (head.port_ok && (head.port == 3'(i))) begin
            rx_r[i] <= rx_inc;
            if (head.fwd) begin
              tx_r[i] <= tx_inc;
            end else begin
              drop_r[i] <= drop_inc;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fwd_r      <= head.fwd;
      reason_r   <= head.reason;
      port_r     <= head.partner;
      ttl_r      <= head.ttl_out;
      csum_r     <= head.fwd ? csum : 16'd0;
      rx_out_r   <= head.port_ok ? rx_inc : 64'd0;
      tx_out_r   <= head.port_ok ? (head.fwd ? tx_inc : tx_sel) : 64'd0;
      drop_out_r <= head.port_ok ? (head.fwd ? drop_sel : drop_inc) : 64'd0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_forward         = fwd_r;
  assign out_drop_reason     = reason_r;
  assign out_port            = port_r;
  assign out_ttl_out         = ttl_r;
  assign out_header_checksum = csum_r;
  assign out_rx_total        = rx_out_r;
  assign out_tx_total        = tx_out_r;
  assign out_drop_total      = drop_out_r;

endmodule

>>> sv/ipv4_acl_forward_filter.sv
// ----------------------------------------------------------------------------
// ipv4_acl_forward_filter
// ipv4 forward filter with one masked acl rule, ttl decrement and counters
// ----------------------------------------------------------------------------
// path: an accepted transaction is written into the queue, then loaded into the
//   result register, which shows it on out_, once that register is free
// throughput: one transaction per cycle while out_stall is low; the counter
//   update and result register share a cycle, so a port may repeat each cycle
// in_stall rises only when the two-entry queue is full (out_stall held)
// reset: counters cleared, rule 10.0.0.0/8 deny, default allow, 8 ports
module ipv4_acl_forward_filter import afw_pkg::*; #(
  parameter int NUM_PORTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // frame summary input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_port,
  input  logic [15:0] in_frame_length,
  input  logic [15:0] in_eth_type,
  input  logic [15:0] in_ver_ihl_tos,
  input  logic [15:0] in_total_length,
  input  logic [15:0] in_ident,
  input  logic [15:0] in_flags_fragment,
  input  logic [7:0]  in_ttl_in,
  input  logic [7:0]  in_protocol,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  // verdict output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_forward,
  output logic [2:0]  out_drop_reason,
  output logic [2:0]  out_port,
  output logic [7:0]  out_ttl_out,
  output logic [15:0] out_header_checksum,
  output logic [63:0] out_rx_total,
  output logic [63:0] out_tx_total,
  output logic [63:0] out_drop_total
);

  cfg_t      cfg_r, cfg_nxt;
  entry_t    front_entry;
  entry_t    q_head;
  q_status_t q_status;
  logic      push;
  logic      pop;

  // ---------------------------------------------------------------------------
  // configuration registers, always ready
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SRC_ADDR:       cfg_nxt.src_ip         = cfg_data;
        CFG_SRC_MASK:       cfg_nxt.src_ip_mask    = cfg_data;
        CFG_DST_ADDR:       cfg_nxt.dst_ip         = cfg_data;
        CFG_DST_MASK:       cfg_nxt.dst_ip_mask    = cfg_data;
        CFG_RULE_PERMIT:    cfg_nxt.rule_permit    = cfg_data[0];
        CFG_DEFAULT_PERMIT: cfg_nxt.default_permit = cfg_data[0];
        CFG_ACTIVE_PORTS:   cfg_nxt.active_ports   = cfg_data[3:0];
        default:            cfg_nxt = cfg_r;  // index past the list is ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_ip         <= 32'h0A00_0000;
      cfg_r.src_ip_mask    <= 32'hFF00_0000;
      cfg_r.dst_ip         <= 32'h0000_0000;
      cfg_r.dst_ip_mask    <= 32'h0000_0000;
      cfg_r.rule_permit    <= 1'b0;
      cfg_r.default_permit <= 1'b1;
      cfg_r.active_ports   <= 4'd8;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // front end: checks in priority order plus header word sum
  // ---------------------------------------------------------------------------
  afw_front #(
    .NUM_PORTS (NUM_PORTS)
  ) u_front (
    .cfg               (cfg_r),
    .in_port           (in_port),
    .in_frame_length   (in_frame_length),
    .in_eth_type       (in_eth_type),
    .in_ver_ihl_tos    (in_ver_ihl_tos),
    .in_total_length   (in_total_length),
    .in_ident          (in_ident),
    .in_flags_fragment (in_flags_fragment),
    .in_ttl_in         (in_ttl_in),
    .in_protocol       (in_protocol),
    .in_src_ip         (in_src_ip),
    .in_dst_ip         (in_dst_ip),
    .entry             (front_entry)
  );

  // stall comes from registered queue state only
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  afw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (q_head),
    .status     (q_status)
  );

  // ---------------------------------------------------------------------------
  // back end: counter read-modify-write, checksum fold, result register
  // ---------------------------------------------------------------------------
  afw_back #(
    .NUM_PORTS (NUM_PORTS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (q_head),
    .q_status            (q_status),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_forward         (out_forward),
    .out_drop_reason     (out_drop_reason),
    .out_port            (out_port),
    .out_ttl_out         (out_ttl_out),
    .out_header_checksum (out_header_checksum),
    .out_rx_total        (out_rx_total),
    .out_tx_total        (out_tx_total),
    .out_drop_total      (out_drop_total)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // every received frame is either forwarded or dropped
  a_counter_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rx_total == out_tx_total + out_drop_total))
    else $error("rx count differs from tx plus drop");

  // a forwarded frame carries no reason and a live ttl
  a_fwd_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_forward) |->
      (out_drop_reason == R_NONE && out_ttl_out != 8'd0))
    else $error("forwarded verdict inconsistent");

  // a dropped frame reports zero ttl and checksum
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_forward) |->
      (out_ttl_out == 8'd0 && out_header_checksum == 16'd0 &&
       out_drop_reason != R_NONE))
    else $error("dropped verdict inconsistent");

  // an empty pipe carries an accepted transaction through the queue to out_valid
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && q_status.empty && !out_valid) |-> ##2 out_valid)
    else $error("accepted transaction did not reach the output");

endmodule
